FILE: rtl/roc_pkg.sv
package roc_pkg;

	// default table depth
	localparam int unsigned MAX_REGIONS_DEF = 16;

	// stream payload widths
	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned S_DATA_W = 64;
	localparam int unsigned M_DATA_W = 16;
	localparam int unsigned ENTRY_W = 2 * ADDR_W;

	// result field widths
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned IDX_W    = 4;
	localparam int unsigned TOTAL_W  = 5;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERLAP  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

	// outcome of one request/entry compare
	typedef struct packed {
		logic stop;      // walk ends at this entry
		logic conflict;  // request overlaps this entry
	} cmp_res_t;

endpackage

FILE: rtl/roc_ram.sv
module roc_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/roc_cmp.sv
module roc_cmp (
	input  logic [roc_pkg::ADDR_W-1:0] req_start,
	input  logic [roc_pkg::ADDR_W:0]   req_end,
	input  logic [roc_pkg::ADDR_W-1:0] ent_start,
	input  logic [roc_pkg::ADDR_W-1:0] ent_size,
	output roc_pkg::cmp_res_t          res
);

	import roc_pkg::*;

	logic [ADDR_W:0] ent_end;
	logic            is_eq;
	logic            is_below;
	logic            reaches;
	logic            is_inside;

	// 33-bit ends never wrap
	assign ent_end   = {1'b0, ent_start} + {1'b0, ent_size};
	assign is_eq     = (req_start == ent_start);
	assign is_below  = (req_start < ent_start);
	assign reaches   = (req_end > {1'b0, ent_start});
	assign is_inside = ({1'b0, req_start} < ent_end);

	// walk stops at same start, at first higher start, or inside an entry
	always_comb begin
		res.stop     = is_eq | is_below | is_inside;
		res.conflict = is_eq | (is_below & reaches) | (~is_below & is_inside);
	end

endmodule

FILE: rtl/region_overlap_checker.sv
// channel  dir  width  contents
// s_*      in   64     request: region_start [31:0], region_size [63:32]
// m_*      out  16     result: status, conflict_index, insert_index, region_total
//
// a request walks the table, reading and comparing each entry up to the
// insert point; it then moves the entries above that point up by one, writes
// the new entry and loads the result. an overlap ends the walk at its entry;
// a full table goes straight to the result, an empty one to the write.
// arst_n clears the count and control; the table is never cleared.
// a result waits in the output register; the next request is taken meanwhile.
module region_overlap_checker #(
	parameter int unsigned MAX_REGIONS = roc_pkg::MAX_REGIONS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [roc_pkg::S_DATA_W-1:0] s_tdata,  // region_start, region_size
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [roc_pkg::M_DATA_W-1:0] m_tdata   // status, conflict_index,
	                                               // insert_index, region_total, pad
);

	import roc_pkg::*;

	localparam int unsigned AW = $clog2(MAX_REGIONS);
	localparam int unsigned CW = $clog2(MAX_REGIONS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]          state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       idx_dec;
	logic                pend_s1;
	logic [CW-1:0]       pend_idx_s1;
	logic [CW-1:0]       place_q;
	logic [ADDR_W-1:0]   req_start_q;
	logic [ADDR_W-1:0]   req_size_q;
	logic [ADDR_W:0]     req_end_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [CW-1:0]       res_conflict_q;
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [ENTRY_W-1:0]  rd_data;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [ENTRY_W-1:0]  wr_data;
	cmp_res_t            cmp_res;
	logic                walk_end;
	logic                shift_end;
	logic                out_free;
	logic [IDX_W-1:0]    res_insert;

	assign s_tready = (state_q == S_IDLE);
	assign idx_dec  = idx_q - CW'(1);
	assign out_free = ~m_tvalid_q | m_tready;

	// table read: walk goes up, shift reads the entry below its destination
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		case (state_q)
			S_WALK: begin
				rd_en = (idx_q < count_q);
			end
			S_SHIFT: begin
				rd_en   = (idx_q > place_q);
				rd_addr = idx_dec[AW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// table write: moved entry or the new region
	always_comb begin
		wr_en   = ((state_q == S_SHIFT) && pend_s1) || (state_q == S_WRITE);
		wr_addr = (state_q == S_WRITE) ? place_q[AW-1:0] : pend_idx_s1[AW-1:0];
		wr_data = (state_q == S_WRITE) ? {req_size_q, req_start_q} : rd_data;
	end

	roc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_REGIONS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	roc_cmp u_cmp (
		.req_start (req_start_q),
		.req_end   (req_end_q),
		.ent_start (rd_data[ADDR_W-1:0]),
		.ent_size  (rd_data[ENTRY_W-1:ADDR_W]),
		.res       (cmp_res)
	);

	// end conditions of the walk and the shift
	assign walk_end  = pend_s1 & (cmp_res.stop | (pend_idx_s1 == count_q - CW'(1)));
	assign shift_end = pend_s1 & (pend_idx_s1 == (place_q + CW'(1)));

	assign res_insert = (res_status_q == ST_INSERTED) ? IDX_W'(place_q) : '0;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			pend_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready && (state_q != S_FIN)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (s_tvalid) begin
						idx_q <= '0;
						if (count_q == CW'(MAX_REGIONS)) begin
							state_q <= S_FIN;
						end else if (count_q == '0) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (rd_en && !walk_end) begin
						idx_q <= idx_q + CW'(1);
					end
					pend_s1 <= rd_en & ~walk_end;
					if (walk_end) begin
						if (cmp_res.conflict) begin
							state_q <= S_FIN;
						end else if (cmp_res.stop) begin
							idx_q   <= count_q;
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_WRITE;
						end
					end
				end
				S_SHIFT: begin
					if (rd_en) begin
						idx_q <= idx_dec;
					end
					pend_s1 <= rd_en & ~shift_end;
					if (shift_end) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					count_q <= count_q + CW'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		pend_idx_s1 <= idx_q;
		case (state_q)
			S_IDLE: begin
				req_start_q    <= s_tdata[ADDR_W-1:0];
				req_size_q     <= s_tdata[S_DATA_W-1:ADDR_W];
				req_end_q      <= {1'b0, s_tdata[ADDR_W-1:0]}
				                  + {1'b0, s_tdata[S_DATA_W-1:ADDR_W]};
				res_conflict_q <= '0;
				place_q        <= '0;
				res_status_q   <= (count_q == CW'(MAX_REGIONS)) ? ST_FULL : ST_INSERTED;
			end
			S_WALK: begin
				if (walk_end) begin
					if (cmp_res.conflict) begin
						res_status_q   <= ST_OVERLAP;
						res_conflict_q <= pend_idx_s1;
					end else if (cmp_res.stop) begin
						place_q <= pend_idx_s1;
					end else begin
						place_q <= count_q;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					m_tdata_q <= {1'b0, TOTAL_W'(count_q), res_insert,
					              IDX_W'(res_conflict_q), res_status_q};
				end
			end
			default: begin
				place_q <= place_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// count stays within the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_REGIONS))
		else $error("region count above table depth");

	// count grows by one on an insert and holds otherwise
	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("count not advanced on insert");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_WRITE) |=> (count_q == $past(count_q)))
		else $error("count changed without insert");

	// a full result comes only from a full table
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && out_free && (res_status_q == ST_FULL))
		|-> (count_q == CW'(MAX_REGIONS)))
		else $error("full status with free entries");

	// the table is written only while moving entries or inserting
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((state_q == S_SHIFT) || (state_q == S_WRITE)))
		else $error("table write outside insert");

endmodule
